### rtl/core/cpct_pkg.sv
// Shared types and constants of the convex polygon collision test core.
`timescale 1ns / 1ps
`default_nettype none
package cpct_pkg;

    localparam int COORD_BITS = 16;
    localparam int ROUNDS_W = 8;
    localparam logic [ROUNDS_W-1:0] LIMIT_RESET = 8'd64;

    typedef enum logic [1:0] {
        STATUS_SEPARATE  = 2'd0,
        STATUS_INTERSECT = 2'd1,
        STATUS_LIMIT     = 2'd2,
        STATUS_BAD_POLY  = 2'd3
    } cpct_status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BEGIN,
        OP_DIR_MUL,
        OP_DIR_SUB,
        OP_SCAN,
        OP_FIRST,
        OP_ROUND,
        OP_ADD,
        OP_GEO_MUL,
        OP_GEO_APPLY,
        OP_CLEAR
    } cpct_op_t;

    typedef struct packed {
        logic                         kind;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } cpct_in_t;

    typedef struct packed {
        cpct_status_t        status;
        logic [ROUNDS_W-1:0] rounds_used;
    } cpct_out_t;

    typedef struct packed {
        cpct_op_t op;
    } cpct_cmd_t;

    typedef struct packed {
        logic                busy;
        logic                bad_poly;
        logic                dir_zero;
        logic                limit_hit;
        logic                dot_nonpos;
        logic                geo_hit;
        logic [ROUNDS_W-1:0] rounds;
    } cpct_stat_t;

endpackage
`default_nettype wire

### rtl/core/convex_polygon_collision_test_core.sv
// Top level of the convex polygon collision test core (2D GJK on two vertex lists).
// Operation: a vertex item is taken and stored; the last item starts a test of R
//   refinement rounds, each set by a scan of n = max(nA, nB) addresses over both vertex
//   stores (one read port each, walked in parallel).
// Throughput: one item per cycle while loading, none while a test runs.
// Reset: rst_n is asynchronous, active low; it clears counts, sums and the result
//   register and sets the iteration limit to 64. Vertex stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module convex_polygon_collision_test_core
    import cpct_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       src_valid,
    output logic            src_ready,
    input  wire cpct_in_t   src_item,
    output logic            res_valid,
    input  wire logic       res_ready,
    output cpct_out_t       res_item,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);

    // The controller issues one command per cycle; the datapath answers with flags.
    cpct_cmd_t  cmd;
    cpct_stat_t stat;

    // The controller also owns the result register, so a finished item can wait
    // for the consumer while the next polygon pair is already being loaded.
    cpct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_last  (src_item.last),
        .src_ready (src_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cmd       (cmd),
        .stat      (stat)
    );

    // The datapath keeps both vertex stores, the running coordinate sums (so the
    // start direction needs no extra pass), the scan pipeline and the simplex.
    cpct_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (src_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stat      (stat)
    );

endmodule
`default_nettype wire

### rtl/core/cpct_datapath.sv
// Datapath: vertex stores, support scan pipeline, simplex and direction arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module cpct_datapath
    import cpct_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cpct_cmd_t        cmd,
    input  wire cpct_in_t         item,
    input  wire logic             cfg_we,
    input  wire logic [7:0]       cfg_wdata,
    output cpct_stat_t            stat
);

    localparam int C      = COORD_BITS;
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int AW     = $clog2(MAX_VERTICES);
    localparam int SUM_W  = C + CW;
    localparam int DM_W   = CW + 1 + SUM_W;
    localparam int DIR_W  = C + 2 * CW + 2;
    localparam int VP_W   = C + DIR_W;
    localparam int VDOT_W = VP_W + 1;
    localparam int PT_W   = C + 1;
    localparam int PP_W   = PT_W + DIR_W;
    localparam int PDOT_W = PP_W + 1;
    localparam int ED_W   = C + 2;
    localparam int GP_W   = 2 * ED_W;
    localparam int T_W    = GP_W + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

    logic [2*C-1:0] mem_a [MAX_VERTICES];
    logic [2*C-1:0] mem_b [MAX_VERTICES];
    logic [2*C-1:0] rd_a_reg, rd_b_reg;

    logic [CW-1:0] cnt_a_reg, cnt_b_reg;
    logic          ovf_reg;
    logic signed [SUM_W-1:0] sum_ax_reg, sum_ay_reg, sum_bx_reg, sum_by_reg;
    logic [ROUNDS_W-1:0] limit_reg, rounds_reg;

    logic signed [DM_W-1:0]  dm0_reg, dm1_reg, dm2_reg, dm3_reg;
    logic signed [DIR_W-1:0] dir_x_reg, dir_y_reg;

    logic [CW-1:0] scan_idx_reg, scan_len;
    logic          scan_active_reg;
    logic          v1_reg, va1_reg, vb1_reg, f1_reg;
    logic          v2_reg, va2_reg, vb2_reg, f2_reg;
    logic signed [C-1:0]    xa2_reg, ya2_reg, xb2_reg, yb2_reg;
    logic signed [VP_W-1:0] pax_reg, pay_reg, pbx_reg, pby_reg;
    logic signed [VDOT_W-1:0] dot_a, dot_b, best_a_reg, best_b_reg;
    logic signed [C-1:0]    bax_reg, bay_reg, bbx_reg, bby_reg;

    logic signed [PT_W-1:0] px, py;
    logic signed [PT_W-1:0] s0x_reg, s0y_reg, s1x_reg, s1y_reg, s2x_reg, s2y_reg;
    logic [1:0]             size_reg;
    logic signed [PP_W-1:0] mdx_reg, mdy_reg;
    logic signed [PDOT_W-1:0] pdot;

    logic signed [PT_W-1:0] oax, oay, obx, oby, ocx, ocy;
    logic signed [ED_W-1:0] abx, aby, acx, acy;
    logic signed [ED_W-1:0] g_abx_reg, g_aby_reg, g_acx_reg, g_acy_reg;
    logic signed [GP_W-1:0] g0_reg, g1_reg, g2_reg, g3_reg, g4_reg, g5_reg;
    logic signed [T_W-1:0]  t1, t2, t3;
    logic                   cond1, cond2, geo_hit;
    logic signed [DIR_W-1:0] e_abx, e_aby, e_acx, e_acy;
    logic                   a_room, b_room;

    assign a_room = cnt_a_reg < MAX_CNT;
    assign b_room = cnt_b_reg < MAX_CNT;

    // Vertex stores: written while loading, read by the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD && !item.kind && a_room)
        begin
            mem_a[cnt_a_reg[AW-1:0]] <= {item.x, item.y};
        end
        rd_a_reg <= mem_a[scan_idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD && item.kind && b_room)
        begin
            mem_b[cnt_b_reg[AW-1:0]] <= {item.x, item.y};
        end
        rd_b_reg <= mem_b[scan_idx_reg[AW-1:0]];
    end

    assign scan_len = (cnt_a_reg > cnt_b_reg) ? cnt_a_reg : cnt_b_reg;

    // Control state: counts, sums, limit, scan sequencing, simplex size, rounds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg       <= '0;
            cnt_b_reg       <= '0;
            ovf_reg         <= 1'b0;
            sum_ax_reg      <= '0;
            sum_ay_reg      <= '0;
            sum_bx_reg      <= '0;
            sum_by_reg      <= '0;
            limit_reg       <= LIMIT_RESET;
            rounds_reg      <= '0;
            scan_idx_reg    <= '0;
            scan_active_reg <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            size_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            v1_reg <= scan_active_reg;
            v2_reg <= v1_reg;
            if (scan_active_reg)
            begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
                if (scan_idx_reg + CW'(1) == scan_len)
                begin
                    scan_active_reg <= 1'b0;
                end
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    if (!item.kind)
                    begin
                        if (a_room)
                        begin
                            cnt_a_reg  <= cnt_a_reg + CW'(1);
                            sum_ax_reg <= sum_ax_reg + SUM_W'(item.x);
                            sum_ay_reg <= sum_ay_reg + SUM_W'(item.y);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        if (b_room)
                        begin
                            cnt_b_reg  <= cnt_b_reg + CW'(1);
                            sum_bx_reg <= sum_bx_reg + SUM_W'(item.x);
                            sum_by_reg <= sum_by_reg + SUM_W'(item.y);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                end
                OP_BEGIN:
                begin
                    rounds_reg <= '0;
                    size_reg   <= '0;
                end
                OP_SCAN:
                begin
                    scan_idx_reg    <= '0;
                    scan_active_reg <= 1'b1;
                end
                OP_ROUND:
                begin
                    rounds_reg      <= rounds_reg + ROUNDS_W'(1);
                    scan_idx_reg    <= '0;
                    scan_active_reg <= 1'b1;
                end
                OP_FIRST:
                begin
                    size_reg <= 2'd1;
                end
                OP_ADD:
                begin
                    size_reg <= size_reg + 2'd1;
                end
                OP_GEO_APPLY:
                begin
                    if (size_reg == 2'd3 && (cond1 || cond2))
                    begin
                        size_reg <= 2'd2;
                    end
                end
                OP_CLEAR:
                begin
                    cnt_a_reg  <= '0;
                    cnt_b_reg  <= '0;
                    ovf_reg    <= 1'b0;
                    sum_ax_reg <= '0;
                    sum_ay_reg <= '0;
                    sum_bx_reg <= '0;
                    sum_by_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Support scan: read, multiply, then compare against the running best.
    assign dot_a = VDOT_W'(pax_reg) + VDOT_W'(pay_reg);
    assign dot_b = VDOT_W'(pbx_reg) + VDOT_W'(pby_reg);

    always_ff @(posedge clk)
    begin
        va1_reg <= scan_idx_reg < cnt_a_reg;
        vb1_reg <= scan_idx_reg < cnt_b_reg;
        f1_reg  <= scan_idx_reg == '0;
        va2_reg <= va1_reg;
        vb2_reg <= vb1_reg;
        f2_reg  <= f1_reg;
        xa2_reg <= $signed(rd_a_reg[2*C-1:C]);
        ya2_reg <= $signed(rd_a_reg[C-1:0]);
        xb2_reg <= $signed(rd_b_reg[2*C-1:C]);
        yb2_reg <= $signed(rd_b_reg[C-1:0]);
        pax_reg <= $signed(rd_a_reg[2*C-1:C]) * dir_x_reg;
        pay_reg <= $signed(rd_a_reg[C-1:0]) * dir_y_reg;
        pbx_reg <= $signed(rd_b_reg[2*C-1:C]) * dir_x_reg;
        pby_reg <= $signed(rd_b_reg[C-1:0]) * dir_y_reg;
        if (v2_reg && va2_reg && (f2_reg || dot_a > best_a_reg))
        begin
            best_a_reg <= dot_a;
            bax_reg    <= xa2_reg;
            bay_reg    <= ya2_reg;
        end
        if (v2_reg && vb2_reg && (f2_reg || dot_b < best_b_reg))
        begin
            best_b_reg <= dot_b;
            bbx_reg    <= xb2_reg;
            bby_reg    <= yb2_reg;
        end
    end

    assign px = PT_W'(bax_reg) - PT_W'(bbx_reg);
    assign py = PT_W'(bay_reg) - PT_W'(bby_reg);
    assign pdot = PDOT_W'(mdx_reg) + PDOT_W'(mdy_reg);

    // Edge operands: the newest point is A; a line uses B, a triangle B and C.
    always_comb
    begin
        if (size_reg == 2'd2)
        begin
            oax = s1x_reg;
            oay = s1y_reg;
            obx = s0x_reg;
            oby = s0y_reg;
        end
        else
        begin
            oax = s2x_reg;
            oay = s2y_reg;
            obx = s1x_reg;
            oby = s1y_reg;
        end
        ocx = s0x_reg;
        ocy = s0y_reg;
    end

    assign abx = ED_W'(obx) - ED_W'(oax);
    assign aby = ED_W'(oby) - ED_W'(oay);
    assign acx = ED_W'(ocx) - ED_W'(oax);
    assign acy = ED_W'(ocy) - ED_W'(oay);

    assign t2 = T_W'(g0_reg) - T_W'(g1_reg);
    assign t1 = T_W'(g2_reg) - T_W'(g3_reg);
    assign t3 = T_W'(g4_reg) - T_W'(g5_reg);

    // Triangle: the AB edge region first, then the AC edge region.
    assign cond1 = (t1 > 0 && t2 > 0) || (t1 < 0 && t2 < 0);
    assign cond2 = (t1 > 0 && t3 < 0) || (t1 < 0 && t3 > 0);
    assign geo_hit = (size_reg == 2'd2) ? (t2 == '0) : !(cond1 || cond2);

    assign e_abx = DIR_W'(g_abx_reg);
    assign e_aby = DIR_W'(g_aby_reg);
    assign e_acx = DIR_W'(g_acx_reg);
    assign e_acy = DIR_W'(g_acy_reg);

    // Payload: start direction, simplex points, search direction.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_DIR_MUL:
            begin
                dm0_reg <= $signed({1'b0, cnt_b_reg}) * sum_ax_reg;
                dm1_reg <= $signed({1'b0, cnt_a_reg}) * sum_bx_reg;
                dm2_reg <= $signed({1'b0, cnt_b_reg}) * sum_ay_reg;
                dm3_reg <= $signed({1'b0, cnt_a_reg}) * sum_by_reg;
            end
            OP_DIR_SUB:
            begin
                dir_x_reg <= DIR_W'(dm0_reg) - DIR_W'(dm1_reg);
                dir_y_reg <= DIR_W'(dm2_reg) - DIR_W'(dm3_reg);
            end
            OP_FIRST:
            begin
                s0x_reg   <= px;
                s0y_reg   <= py;
                dir_x_reg <= -dir_x_reg;
                dir_y_reg <= -dir_y_reg;
            end
            OP_ADD:
            begin
                if (size_reg == 2'd1)
                begin
                    s1x_reg <= px;
                    s1y_reg <= py;
                end
                else
                begin
                    s2x_reg <= px;
                    s2y_reg <= py;
                end
                mdx_reg <= px * dir_x_reg;
                mdy_reg <= py * dir_y_reg;
            end
            OP_GEO_MUL:
            begin
                g_abx_reg <= abx;
                g_aby_reg <= aby;
                g_acx_reg <= acx;
                g_acy_reg <= acy;
                g0_reg <= aby * oax;
                g1_reg <= abx * oay;
                g2_reg <= acx * aby;
                g3_reg <= acy * abx;
                g4_reg <= acy * oax;
                g5_reg <= acx * oay;
            end
            OP_GEO_APPLY:
            begin
                if (size_reg == 2'd2)
                begin
                    if (t2 > 0)
                    begin
                        dir_x_reg <= -e_aby;
                        dir_y_reg <= e_abx;
                    end
                    else if (t2 < 0)
                    begin
                        dir_x_reg <= e_aby;
                        dir_y_reg <= -e_abx;
                    end
                end
                else if (cond1)
                begin
                    s0x_reg <= s1x_reg;
                    s0y_reg <= s1y_reg;
                    s1x_reg <= s2x_reg;
                    s1y_reg <= s2y_reg;
                    if (t1 > 0)
                    begin
                        dir_x_reg <= -e_aby;
                        dir_y_reg <= e_abx;
                    end
                    else
                    begin
                        dir_x_reg <= e_aby;
                        dir_y_reg <= -e_abx;
                    end
                end
                else if (cond2)
                begin
                    s1x_reg <= s2x_reg;
                    s1y_reg <= s2y_reg;
                    if (t1 > 0)
                    begin
                        dir_x_reg <= e_acy;
                        dir_y_reg <= -e_acx;
                    end
                    else
                    begin
                        dir_x_reg <= -e_acy;
                        dir_y_reg <= e_acx;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.busy       = scan_active_reg | v1_reg | v2_reg;
    assign stat.bad_poly   = ovf_reg || cnt_a_reg == '0 || cnt_b_reg == '0;
    assign stat.dir_zero   = dir_x_reg == '0 && dir_y_reg == '0;
    assign stat.limit_hit  = rounds_reg >= limit_reg;
    assign stat.dot_nonpos = pdot <= 0;
    assign stat.geo_hit    = geo_hit;
    assign stat.rounds     = rounds_reg;

endmodule
`default_nettype wire

### rtl/core/cpct_ctrl.sv
// Controller: sequences loading, the support scans and the simplex rounds, holds the result.
`timescale 1ns / 1ps
`default_nettype none
module cpct_ctrl
    import cpct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       src_valid,
    input  wire logic       src_last,
    output logic            src_ready,
    output logic            res_valid,
    input  wire logic       res_ready,
    output cpct_out_t       res_item,
    output cpct_cmd_t       cmd,
    input  wire cpct_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIRMUL,
        S_DIRSUB,
        S_DIRTEST,
        S_FSCAN,
        S_RCHECK,
        S_RSCAN,
        S_DOT,
        S_GEOAPP,
        S_DONE
    } state_t;

    state_t       state_reg, state_next;
    cpct_status_t code_reg, code_next;
    logic         res_valid_reg, res_valid_next;
    cpct_out_t    res_item_reg, res_item_next;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_item_next  = res_item_reg;
        cmd.op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (src_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (src_last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                cmd.op = OP_BEGIN;
                if (stat.bad_poly)
                begin
                    code_next  = STATUS_BAD_POLY;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIRMUL;
                end
            end
            S_DIRMUL:
            begin
                cmd.op     = OP_DIR_MUL;
                state_next = S_DIRSUB;
            end
            S_DIRSUB:
            begin
                cmd.op     = OP_DIR_SUB;
                state_next = S_DIRTEST;
            end
            S_DIRTEST:
            begin
                if (stat.dir_zero)
                begin
                    code_next  = STATUS_INTERSECT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_SCAN;
                    state_next = S_FSCAN;
                end
            end
            S_FSCAN:
            begin
                if (!stat.busy)
                begin
                    cmd.op     = OP_FIRST;
                    state_next = S_RCHECK;
                end
            end
            S_RCHECK:
            begin
                if (stat.limit_hit)
                begin
                    code_next  = STATUS_LIMIT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_ROUND;
                    state_next = S_RSCAN;
                end
            end
            S_RSCAN:
            begin
                if (!stat.busy)
                begin
                    cmd.op     = OP_ADD;
                    state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                if (stat.dot_nonpos)
                begin
                    code_next  = STATUS_SEPARATE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_GEO_MUL;
                    state_next = S_GEOAPP;
                end
            end
            S_GEOAPP:
            begin
                cmd.op = OP_GEO_APPLY;
                if (stat.geo_hit)
                begin
                    code_next  = STATUS_INTERSECT;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RCHECK;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    cmd.op                    = OP_CLEAR;
                    res_valid_next            = 1'b1;
                    res_item_next.status      = code_reg;
                    res_item_next.rounds_used = stat.rounds;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            code_reg      <= STATUS_SEPARATE;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            res_valid_reg <= res_valid_next;
            res_item_reg  <= res_item_next;
        end
    end

    assign src_ready = state_reg == S_IDLE;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule
`default_nettype wire

### rtl/core/cpct_checker.sv
// Port checker for the convex polygon collision test core, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module cpct_checker
    import cpct_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      src_valid,
    input wire logic      src_ready,
    input wire cpct_in_t  src_item,
    input wire logic      res_valid,
    input wire logic      res_ready,
    input wire cpct_out_t res_item
);

    // A waiting result item holds until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result item changed while stalled");

    // The last vertex starts a test, so no item is taken in the next cycle.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready && src_item.last |=> !src_ready)
        else $error("item taken while a test runs");

    // A rejected polygon pair never runs a refinement round.
    a_bad_zero_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.status == STATUS_BAD_POLY |-> res_item.rounds_used == '0)
        else $error("bad polygon reported with rounds");

endmodule

bind convex_polygon_collision_test_core cpct_checker u_cpct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
);
`default_nettype wire
